FILE: sv/positional_list_store_assert.svh
// Assertion macros used by the list store execution module, plst_back.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PLST_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("list store check failed");

`define PLST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list store check failed");

`define PLST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list store check failed");

`else

`define PLST_ASSERT(label, clk, rst, prop)
`define PLST_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PLST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/plst_pkg.sv
`timescale 1ns / 1ps

package plst_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 5;
  // Wide enough for any position and any occupancy plus one.
  localparam int CMP_W        = 9;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_COUNT     = 3'd6,
    CMD_DUMP      = 3'd7
  } command_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    command_t                   command;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
  } cmd_t;

  typedef struct packed {
    status_t                    status;
    logic [COUNT_W-1:0]         element_count;
    logic signed [VALUE_W-1:0]  element;
    logic                       last;
  } rsp_t;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_DELETE = 2'd1,
    K_COUNT  = 2'd2,
    K_DUMP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    W_FRONT = 2'd0,
    W_BACK  = 2'd1,
    W_POS   = 2'd2
  } where_t;

  typedef struct packed {
    kind_t                      kind;
    where_t                     where;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;
  } op_t;

endpackage

FILE: sv/plst_front.sv
`timescale 1ns / 1ps

module plst_front import plst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd_data,
  output logic op_valid,
  input  logic op_ready,
  output op_t  op
);

  op_t        queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  op_t        decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.value    = cmd_data.value;
    decoded.position = cmd_data.position;
    unique case (cmd_data.command)
      CMD_INS_FRONT: begin
        decoded.kind  = K_INSERT;
        decoded.where = W_FRONT;
      end
      CMD_INS_BACK: begin
        decoded.kind  = K_INSERT;
        decoded.where = W_BACK;
      end
      CMD_INS_POS: begin
        decoded.kind  = K_INSERT;
        decoded.where = W_POS;
      end
      CMD_DEL_FRONT: begin
        decoded.kind  = K_DELETE;
        decoded.where = W_FRONT;
      end
      CMD_DEL_BACK: begin
        decoded.kind  = K_DELETE;
        decoded.where = W_BACK;
      end
      CMD_DEL_POS: begin
        decoded.kind  = K_DELETE;
        decoded.where = W_POS;
      end
      CMD_COUNT: begin
        decoded.kind  = K_COUNT;
        decoded.where = W_FRONT;
      end
      default: begin
        decoded.kind  = K_DUMP;
        decoded.where = W_FRONT;
      end
    endcase
  end

  assign cmd_stall = (fill == 2'd2);
  assign op_valid  = (fill != 2'd0);
  assign op        = queue[rd_ptr];
  assign push      = cmd_valid && !cmd_stall;
  assign pop       = op_valid && op_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   fill_next = fill + 2'd1;
      2'b01:   fill_next = fill - 2'd1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

endmodule

FILE: sv/plst_back.sv
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"

module plst_back import plst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_RUN  = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    SLOT_HOLD = 2'd0,
    SLOT_INS  = 2'd1,
    SLOT_DEL  = 2'd2,
    SLOT_ROT  = 2'd3
  } slot_op_t;

  state_t                     state;
  state_t                     state_next;
  logic [OCC_W-1:0]           occ;
  logic [OCC_W-1:0]           occ_next;
  logic [OCC_W-1:0]           cnt;
  logic [OCC_W-1:0]           cnt_next;
  logic signed [VALUE_W-1:0]  slots      [CAPACITY];
  logic signed [VALUE_W-1:0]  slots_next [CAPACITY];
  rsp_t                       rsp_data_next;
  logic                       rsp_valid_next;
  slot_op_t                   slot_op;
  logic [CMP_W-1:0]           idx;
  logic [CMP_W-1:0]           occ_x;
  logic [CMP_W-1:0]           pos_x;
  logic                       out_free;
  logic                       emit;
  status_t                    st;
  logic signed [VALUE_W-1:0]  elem;
  logic                       last;
  logic [OCC_W+COUNT_W-1:0]   count_ext;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign op_ready  = (state == S_RUN) && out_free;
  assign occ_x     = CMP_W'(occ);
  assign pos_x     = CMP_W'(op.position);
  assign count_ext = {{COUNT_W{1'b0}}, occ_next};

  always_comb begin
    state_next = state;
    occ_next   = occ;
    cnt_next   = cnt;
    slot_op    = SLOT_HOLD;
    idx        = '0;
    emit       = 1'b0;
    st         = ST_OK;
    elem       = '0;
    last       = 1'b1;
    unique case (state)
      S_RUN: begin
        if (op_valid && out_free) begin
          emit = 1'b1;
          unique case (op.kind)
            K_INSERT: begin
              if (op.where == W_POS &&
                  (pos_x == '0 || pos_x > occ_x + CMP_W'(1))) begin
                st = ST_BADPOS;
              end else if (occ == OCC_W'(CAPACITY)) begin
                st = ST_FULL;
              end else begin
                slot_op  = SLOT_INS;
                occ_next = occ + OCC_W'(1);
                if (op.where == W_FRONT) begin
                  idx = '0;
                end else if (op.where == W_BACK) begin
                  idx = occ_x;
                end else begin
                  idx = pos_x - CMP_W'(1);
                end
              end
            end
            K_DELETE: begin
              if (occ == '0) begin
                st = ST_EMPTY;
              end else if (op.where == W_POS && (pos_x == '0 || pos_x > occ_x)) begin
                st = ST_BADPOS;
              end else begin
                slot_op  = SLOT_DEL;
                occ_next = occ - OCC_W'(1);
                if (op.where == W_FRONT) begin
                  idx = '0;
                end else if (op.where == W_BACK) begin
                  idx = occ_x - CMP_W'(1);
                end else begin
                  idx = pos_x - CMP_W'(1);
                end
              end
            end
            K_COUNT: begin
              st = ST_OK;
            end
            K_DUMP: begin
              if (occ == '0) begin
                st = ST_EMPTY;
              end else begin
                elem     = slots[0];
                slot_op  = SLOT_ROT;
                cnt_next = OCC_W'(1);
                last     = (occ == OCC_W'(1));
                if (occ != OCC_W'(1)) begin
                  state_next = S_DUMP;
                end
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit     = 1'b1;
          elem     = slots[0];
          slot_op  = SLOT_ROT;
          cnt_next = cnt + OCC_W'(1);
          last     = (cnt + OCC_W'(1) == occ);
          if (cnt + OCC_W'(1) == occ) begin
            state_next = S_RUN;
          end
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_data_next  = rsp_data;
    if (emit) begin
      rsp_valid_next              = 1'b1;
      rsp_data_next.status        = st;
      rsp_data_next.element_count = count_ext[COUNT_W-1:0];
      rsp_data_next.element       = elem;
      rsp_data_next.last          = last;
    end
  end

  // All slots update in parallel: those from the index upward shift up on insert and
  // down on delete, and the occupied slots rotate by one during a dump.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic signed [VALUE_W-1:0] prev_v;
    logic signed [VALUE_W-1:0] succ_v;

    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid
      assign prev_v = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign succ_v = slots[0];
    end else begin : g_inner
      assign succ_v = slots[i+1];
    end

    always_comb begin
      unique case (slot_op)
        SLOT_HOLD: slots_next[i] = slots[i];
        SLOT_INS: begin
          if (CMP_W'(i) < idx) begin
            slots_next[i] = slots[i];
          end else if (CMP_W'(i) == idx) begin
            slots_next[i] = op.value;
          end else begin
            slots_next[i] = prev_v;
          end
        end
        SLOT_DEL: slots_next[i] = (CMP_W'(i) < idx) ? slots[i] : succ_v;
        SLOT_ROT: slots_next[i] = (CMP_W'(i) + CMP_W'(1) < occ_x) ? succ_v : slots[0];
      endcase
    end

    always_ff @(posedge clk) begin
      slots[i] <= slots_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      occ       <= '0;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      occ       <= occ_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rsp_data <= rsp_data_next;
  end

  `PLST_ASSERT(a_occ_bound, clk, rst, occ <= OCC_W'(CAPACITY))
  `PLST_ASSERT_IMPLY(a_dump_cnt, clk, rst, state == S_DUMP, cnt != '0 && cnt < occ)
  `PLST_ASSERT_NEXT(a_occ_hold, clk, rst, !(op_valid && op_ready), $stable(occ))

endmodule

FILE: sv/positional_list_store.sv
// A command is registered in the command queue, and its first result in the result register.
// Throughput: one command per cycle for inserts, deletes and counts while the result
// output is not stalled; a dump of n elements holds the execution stage until all n
// results are out, one per cycle while unstalled. The slots shift or rotate in parallel.
// Reset clears the command queue, the occupancy, the sequencer and the result valid;
// slot contents are not cleared and are only read below the occupancy.
`timescale 1ns / 1ps

module positional_list_store import plst_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  logic op_valid;
  logic op_ready;
  op_t  op;

  plst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op)
  );

  plst_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import plst_pkg::*;

  localparam int DEPTH       = DEF_CAPACITY;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CMDS = 290;

  typedef struct {
    cmd_t c;
    bit   hold;
    int   tx_pct;
    int   rx_pct;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_data;

  job_t cmd_backlog[$];
  rsp_t pending_results[$];
  job_t next_job;
  rsp_t want_rsp;

  logic signed [VALUE_W-1:0] list_cells [DEPTH];
  int list_len = 0;

  int rsp_idle_pct = 0;
  int n_accepted = 0;
  int n_predicted = 0;
  int n_received = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int status_hits [4];

  bit hold_next = 1'b0;
  int tx_pct_now = 16;
  int rx_pct_now = 54;

  positional_list_store #(.CAPACITY(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data(cmd_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  task automatic advance_list(input cmd_t c);
    status_t st;
    rsp_t r;
    int p;
    int idx;
    int i;
    st = ST_OK;
    p = int'(c.position);
    case (c.command)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS: begin
        if (c.command == CMD_INS_POS && (p < 1 || p > list_len + 1)) begin
          st = ST_BADPOS;
        end else if (list_len >= DEPTH) begin
          st = ST_FULL;
        end else begin
          if (c.command == CMD_INS_FRONT) idx = 0;
          else if (c.command == CMD_INS_BACK) idx = list_len;
          else idx = p - 1;
          for (i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
          list_cells[idx] = c.value;
          list_len++;
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (c.command == CMD_DEL_POS && (p < 1 || p > list_len)) begin
          st = ST_BADPOS;
        end else begin
          if (c.command == CMD_DEL_FRONT) idx = 0;
          else if (c.command == CMD_DEL_BACK) idx = list_len - 1;
          else idx = p - 1;
          for (i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) st = ST_EMPTY;
      end
      default: begin
      end
    endcase
    status_hits[st]++;
    r.status = st;
    r.element_count = COUNT_W'(list_len);
    if (c.command == CMD_DUMP && list_len > 0) begin
      for (i = 0; i < list_len; i++) begin
        r.element = list_cells[i];
        r.last = (i + 1 == list_len);
        pending_results.push_back(r);
        n_predicted++;
      end
    end else begin
      r.element = '0;
      r.last = 1'b1;
      pending_results.push_back(r);
      n_predicted++;
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_position();
    if ($urandom_range(99) < 80) return $urandom_range(0, DEPTH + 1);
    return $urandom_range(0, 255);
  endfunction

  task automatic queue_cmd(input command_t op, input logic signed [VALUE_W-1:0] v,
                           input int p);
    job_t j;
    j.c.command = op;
    j.c.value = v;
    j.c.position = POS_W'(p);
    j.hold = hold_next;
    j.tx_pct = tx_pct_now;
    j.rx_pct = rx_pct_now;
    hold_next = 1'b0;
    cmd_backlog.push_back(j);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        advance_list(cmd_data);
        n_accepted++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() == 0) begin
          cmd_valid <= 1'b0;
        end else if (cmd_backlog[0].hold && n_received != n_predicted) begin
          cmd_valid <= 1'b0;
        end else if ($urandom_range(99) < cmd_backlog[0].tx_pct) begin
          cmd_valid <= 1'b0;
        end else begin
          next_job = cmd_backlog.pop_front();
          cmd_data <= next_job.c;
          cmd_valid <= 1'b1;
          rsp_idle_pct <= next_job.rx_pct;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_received <= n_received + 1;
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with none expected, element",
                          longint'(rsp_data.element), 0);
        end else begin
          want_rsp = pending_results.pop_front();
          if (rsp_data.status != want_rsp.status)
            report_mismatch("status", longint'(rsp_data.status), longint'(want_rsp.status));
          if (rsp_data.element_count != want_rsp.element_count)
            report_mismatch("element_count", longint'(rsp_data.element_count),
                            longint'(want_rsp.element_count));
          if (rsp_data.element !== want_rsp.element)
            report_mismatch("element", longint'(rsp_data.element),
                            longint'(want_rsp.element));
          if (rsp_data.last !== want_rsp.last)
            report_mismatch("last", longint'(rsp_data.last), longint'(want_rsp.last));
        end
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end
  end

  initial begin
    int n_rand;
    int event_no;
    int roll;
    int phase;
    int last_phase;
    command_t op;

    foreach (status_hits[k]) status_hits[k] = 0;

    queue_cmd(CMD_DUMP, 0, 0);
    queue_cmd(CMD_COUNT, 0, 0);
    queue_cmd(CMD_DEL_FRONT, 0, 0);
    queue_cmd(CMD_DEL_BACK, 0, 0);
    queue_cmd(CMD_DEL_POS, 0, 0);
    queue_cmd(CMD_INS_POS, 5, 0);
    queue_cmd(CMD_INS_POS, 6, 2);
    queue_cmd(CMD_INS_POS, {1'b0, {(VALUE_W-1){1'b1}}}, 1);
    queue_cmd(CMD_INS_FRONT, {1'b1, {(VALUE_W-1){1'b0}}}, 0);
    queue_cmd(CMD_INS_BACK, '1, 255);
    queue_cmd(CMD_INS_POS, 0, 4);
    queue_cmd(CMD_INS_POS, 7, 255);
    queue_cmd(CMD_DEL_POS, 0, 0);
    queue_cmd(CMD_DEL_POS, 0, 5);
    queue_cmd(CMD_DEL_POS, 0, 2);
    queue_cmd(CMD_DUMP, 0, 0);
    queue_cmd(CMD_DEL_FRONT, 0, 0);
    queue_cmd(CMD_DEL_BACK, 0, 0);
    queue_cmd(CMD_COUNT, 0, 0);
    queue_cmd(CMD_DUMP, 0, 0);

    n_rand = 0;
    event_no = 0;
    last_phase = 0;
    while (n_rand < RANDOM_CMDS) begin
      phase = (n_rand < RANDOM_CMDS / 3) ? 0 : (n_rand < 2 * RANDOM_CMDS / 3) ? 1 : 2;
      if (phase != last_phase) hold_next = 1'b1;
      last_phase = phase;
      tx_pct_now = (phase == 0) ? 16 : (phase == 1) ? 54 : 0;
      rx_pct_now = (phase == 0) ? 54 : (phase == 1) ? 16 : 0;
      if ($urandom_range(99) < 3) hold_next = 1'b1;

      roll = (event_no == 0) ? 0 : (event_no == 1) ? 15 : $urandom_range(99);
      if (roll < 10) begin
        repeat (DEPTH + 1) begin
          case ($urandom_range(2))
            0: queue_cmd(CMD_INS_FRONT, pick_value(), pick_position());
            1: queue_cmd(CMD_INS_BACK, pick_value(), pick_position());
            default: queue_cmd(CMD_INS_POS, pick_value(), 1);
          endcase
        end
        queue_cmd(CMD_INS_POS, pick_value(), DEPTH + 2);
        queue_cmd(CMD_INS_POS, pick_value(), DEPTH + 1);
        queue_cmd(CMD_INS_FRONT, pick_value(), 0);
        queue_cmd(CMD_DUMP, pick_value(), pick_position());
        n_rand += DEPTH + 5;
      end else if (roll < 18) begin
        repeat (DEPTH + 1) begin
          case ($urandom_range(2))
            0: queue_cmd(CMD_DEL_FRONT, pick_value(), pick_position());
            1: queue_cmd(CMD_DEL_BACK, pick_value(), pick_position());
            default: queue_cmd(CMD_DEL_POS, pick_value(), 1);
          endcase
        end
        queue_cmd(CMD_DEL_POS, pick_value(), 0);
        queue_cmd(CMD_DUMP, pick_value(), pick_position());
        queue_cmd(CMD_COUNT, pick_value(), pick_position());
        n_rand += DEPTH + 4;
      end else begin
        op = command_t'($urandom_range(7));
        queue_cmd(op, pick_value(), pick_position());
        n_rand++;
      end
      event_no++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || cmd_valid || n_received != n_predicted)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending_results.size() != 0)
      report_mismatch("results still expected at end", 0, pending_results.size());

    $display("summary: %0d commands accepted, %0d result transactions checked",
             n_accepted, n_received);
    $display("summary: status ok %0d, bad position %0d, full %0d, empty %0d",
             status_hits[ST_OK], status_hits[ST_BADPOS], status_hits[ST_FULL],
             status_hits[ST_EMPTY]);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: positional_list_store.f
+incdir+sv
sv/plst_pkg.sv
sv/plst_front.sv
sv/plst_back.sv
sv/positional_list_store.sv
dv/tb_top.sv
